// ----- rtl/core/cfe_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfe_pkg;

  localparam int FRAME_BYTES = 1024;
  localparam int POS_W       = $clog2(FRAME_BYTES + 1);
  localparam int OFF_W       = $clog2(FRAME_BYTES);
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  localparam logic [7:0]       CODE_MAX   = 8'hFF;
  localparam logic [7:0]       CODE_START = 8'h01;
  localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(FRAME_BYTES);

  // one buffer write request
  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic [7:0]       data;
    logic             done;
    logic [POS_W-1:0] length;
    logic             overflow;
  } cfe_wr_t;

  // up to two write requests produced by one input item
  typedef struct packed {
    logic [1:0] cnt;
    cfe_wr_t    rec0;
    cfe_wr_t    rec1;
  } cfe_push_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              pop;
  } cfe_qstat_t;

  // advance a write position, holding at the buffer size
  function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
    sat_inc = (p < POS_LIMIT) ? p + POS_W'(1) : p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/cfe_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfe_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  input  wire logic               stuff_en,
  output cfe_pkg::cfe_push_t      push
);
  import cfe_pkg::*;

  logic [POS_W-1:0] wp_r, wp_nxt;
  logic [POS_W-1:0] cs_r, cs_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             res_r, res_nxt;
  logic             ovf_r, ovf_nxt;

  logic [POS_W-1:0] wp1, wp2, wp3, cs1, cs3;
  logic [7:0]       code1, code2, code3;
  logic             a_try, b_try;
  logic [POS_W-1:0] a_pos, b_pos;
  logic [7:0]       a_val, b_val;
  logic             a_done, a_drop, a_ovf, b_drop, b_ovf;
  cfe_wr_t          a_rec, b_rec;

  always_comb begin
    wp1 = wp_r; wp2 = wp_r; wp3 = wp_r;
    cs1 = cs_r; cs3 = cs_r;
    code1 = code_r; code2 = code_r; code3 = code_r;
    a_try = 1'b0; b_try = 1'b0;
    a_pos = wp_r; b_pos = wp_r;
    a_val = data_byte; b_val = code_r;
    a_done = 1'b0;

    if (!stuff_en) begin
      // copy mode: one write at the next free offset
      a_try  = 1'b1;
      a_pos  = wp_r;
      a_val  = data_byte;
      a_done = last_byte;
      wp3    = sat_inc(wp_r);
    end else begin
      // open a block when none is pending
      if (!res_r) begin
        cs1   = wp_r;
        code1 = CODE_START;
        wp1   = sat_inc(wp_r);
      end
      a_try = 1'b1;
      if (data_byte != 8'd0) begin
        a_pos = wp1;
        a_val = data_byte;
        wp2   = sat_inc(wp1);
        code2 = code1 + 8'd1;
        if (code2 == CODE_MAX && !last_byte) begin
          b_try = 1'b1;
          b_pos = cs1;
          b_val = CODE_MAX;
          cs3   = wp2;
          code3 = CODE_START;
          wp3   = sat_inc(wp2);
        end else begin
          cs3   = cs1;
          code3 = code2;
          wp3   = wp2;
        end
      end else begin
        // zero closes the block and reserves the next slot
        a_pos = cs1;
        a_val = code1;
        cs3   = wp1;
        code3 = CODE_START;
        wp3   = sat_inc(wp1);
      end
      if (last_byte) begin
        b_try = 1'b1;
        b_pos = cs3;
        b_val = code3;
      end
    end
  end

  always_comb begin
    a_drop = a_pos >= POS_LIMIT;
    a_ovf  = ovf_r | a_drop;
    b_drop = b_pos >= POS_LIMIT;
    b_ovf  = a_ovf | b_drop;

    a_rec.offset   = a_drop ? '0 : a_pos[OFF_W-1:0];
    a_rec.data     = a_drop ? 8'd0 : a_val;
    a_rec.done     = a_done;
    a_rec.length   = a_done ? wp3 : '0;
    a_rec.overflow = a_ovf;

    // the second write, when present and in COBS mode, is final or a code write
    b_rec.offset   = b_drop ? '0 : b_pos[OFF_W-1:0];
    b_rec.data     = b_drop ? 8'd0 : b_val;
    b_rec.done     = last_byte;
    b_rec.length   = last_byte ? wp3 : '0;
    b_rec.overflow = b_ovf;
  end

  always_comb begin
    logic a_keep, b_keep;
    a_keep = a_try & (!a_drop | a_done);
    b_keep = b_try & (!b_drop | last_byte);
    push.rec0 = a_keep ? a_rec : b_rec;
    push.rec1 = b_rec;
    push.cnt  = in_fire ? (2'(a_keep) + 2'(b_keep)) : 2'd0;
  end

  always_comb begin
    if (last_byte) begin
      wp_nxt   = '0;
      cs_nxt   = '0;
      code_nxt = CODE_START;
      res_nxt  = 1'b0;
      ovf_nxt  = 1'b0;
    end else if (!stuff_en) begin
      wp_nxt   = wp3;
      cs_nxt   = cs_r;
      code_nxt = code_r;
      res_nxt  = res_r;
      ovf_nxt  = a_ovf;
    end else begin
      wp_nxt   = wp3;
      cs_nxt   = cs3;
      code_nxt = code3;
      res_nxt  = 1'b1;
      ovf_nxt  = b_try ? b_ovf : a_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      cs_r   <= '0;
      code_r <= CODE_START;
      res_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end else if (in_fire) begin
      wp_r   <= wp_nxt;
      cs_r   <= cs_nxt;
      code_r <= code_nxt;
      res_r  <= res_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cfe_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfe_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfe_pkg::cfe_push_t push,
  input  wire logic               pop_ready,
  output logic                    head_valid,
  output cfe_pkg::cfe_wr_t        head,
  output cfe_pkg::cfe_qstat_t     stat
);
  import cfe_pkg::*;

  cfe_wr_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign pop        = head_valid & pop_ready;
  assign stat.count = cnt_r;
  assign stat.pop   = pop;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.cnt) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[wr_ptr_r] <= push.rec0;
    if (push.cnt == 2'd2) mem_r[wr_ptr_r + QPTR_W'(1)] <= push.rec1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/cobs_frame_encoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming COBS encoder that writes an encoded frame into a byte buffer.
// Input channel (in_valid/in_ready): one raw frame byte per request, with
// in_last_byte set on the frame's final byte.
// Output channel (out_valid/out_ready): one buffer write per request, as an
// offset and a byte; code slots are backpatched by later writes. The frame's
// final write carries out_frame_done and the encoded length; non-final
// writes beyond the buffer are dropped and flagged through out_overflow.
// Configuration (cfg_valid/cfg_ready): cfg_stuffing_enable selects COBS
// encoding (1, the reset value) or plain copy (0); always ready.
// Ordering: a byte's writes are registered in the write queue and leave it
// behind earlier writes; a second write from the same byte follows its first.
// Throughput: one byte per cycle while each byte makes at most one write and
// out_ready is high; the output drains one write per cycle while out_ready is
// high, so bytes that make two writes (a nonzero byte that fills a block, the
// last byte of a COBS frame) fill the queue and can hold the input side.
// Four-entry write queue between front and output; in_ready drops when fewer
// than two entries are free, so a stalled receiver holds the input side.
// Reset clears frame state, the queue and sets stuffing enabled.
module cobs_frame_encoder_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_data_byte,
  input  wire logic                        in_last_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [cfe_pkg::OFF_W-1:0]        out_offset,
  output logic [7:0]                       out_byte,
  output logic                             out_frame_done,
  output logic [cfe_pkg::POS_W-1:0]        out_frame_length,
  output logic                             out_overflow,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic                        cfg_stuffing_enable
);
  import cfe_pkg::*;

  logic       stuff_en_r;
  logic       in_fire;
  cfe_push_t  push;
  cfe_wr_t    head;
  cfe_qstat_t qstat;

  // accept a byte only when the queue can absorb two writes
  assign in_ready  = qstat.count <= QCNT_W'(QDEPTH - 2);
  assign in_fire   = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stuff_en_r <= 1'b1;
    end else if (cfg_valid) begin
      stuff_en_r <= cfg_stuffing_enable;
    end
  end

  // front: classify the byte, update block state, form writes
  cfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .stuff_en  (stuff_en_r),
    .push      (push)
  );

  // back: queue the writes and present them one per request
  cfe_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop_ready  (out_ready),
    .head_valid (out_valid),
    .head       (head),
    .stat       (qstat)
  );

  assign out_offset       = head.offset;
  assign out_byte         = head.data;
  assign out_frame_done   = head.done;
  assign out_frame_length = head.length;
  assign out_overflow     = head.overflow;

  // queue occupancy never exceeds its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("write queue over depth");

  // occupancy follows pushes and pops
  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> qstat.count ==
      $past(qstat.count) + QCNT_W'($past(push.cnt)) - QCNT_W'($past(qstat.pop)))
    else $error("write queue count mismatch");

  // a final write always reports a nonzero length
  a_done_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_frame_length != '0)
    else $error("final write with zero length");

  // non-final writes carry no length
  a_mid_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_frame_length == '0)
    else $error("length on non-final write");

endmodule

`default_nettype wire
